### design/mcu_dec_pkg.sv
// ----------------------------------------------------------------------------
// mcu_dec_pkg
// Shared types, the instruction pattern table and form codes of the decoder.
// ----------------------------------------------------------------------------
package mcu_dec_pkg;

  localparam int unsigned NumPats = 96;

  typedef logic [6:0] form_t;

  localparam form_t FORM_UNKNOWN = 7'd0;
  localparam form_t FORM_ADC     = 7'd1;
  localparam form_t FORM_ROL     = 7'd2;
  localparam form_t FORM_ADD     = 7'd3;
  localparam form_t FORM_LSL     = 7'd4;
  localparam form_t FORM_ADIW    = 7'd5;
  localparam form_t FORM_AND     = 7'd6;
  localparam form_t FORM_TST     = 7'd7;
  localparam form_t FORM_ANDI    = 7'd8;
  localparam form_t FORM_ASR     = 7'd9;
  localparam form_t FORM_BCLR    = 7'd10;
  localparam form_t FORM_BLD     = 7'd11;
  localparam form_t FORM_BRBC    = 7'd12;
  localparam form_t FORM_BRBS    = 7'd13;
  localparam form_t FORM_BREAK   = 7'd14;
  localparam form_t FORM_BST     = 7'd15;
  localparam form_t FORM_CALL    = 7'd16;
  localparam form_t FORM_CBI     = 7'd17;
  localparam form_t FORM_COM     = 7'd18;
  localparam form_t FORM_CP      = 7'd19;
  localparam form_t FORM_CPC     = 7'd20;
  localparam form_t FORM_CPI     = 7'd21;
  localparam form_t FORM_CPSE    = 7'd22;
  localparam form_t FORM_DEC     = 7'd23;
  localparam form_t FORM_EICALL  = 7'd24;
  localparam form_t FORM_EIJMP   = 7'd25;
  localparam form_t FORM_ELPM    = 7'd26;
  localparam form_t FORM_ELPM_Z  = 7'd27;
  localparam form_t FORM_ELPM_ZP = 7'd28;
  localparam form_t FORM_EOR     = 7'd29;
  localparam form_t FORM_CLR     = 7'd30;
  localparam form_t FORM_ESPM    = 7'd31;
  localparam form_t FORM_FMUL    = 7'd32;
  localparam form_t FORM_FMULS   = 7'd33;
  localparam form_t FORM_FMULSU  = 7'd34;
  localparam form_t FORM_ICALL   = 7'd35;
  localparam form_t FORM_IJMP    = 7'd36;
  localparam form_t FORM_IN      = 7'd37;
  localparam form_t FORM_INC     = 7'd38;
  localparam form_t FORM_JMP     = 7'd39;
  localparam form_t FORM_LD_Y    = 7'd40;
  localparam form_t FORM_LD_YP   = 7'd41;
  localparam form_t FORM_LD_Z    = 7'd42;
  localparam form_t FORM_LD_ZP   = 7'd43;
  localparam form_t FORM_LD_MX   = 7'd44;
  localparam form_t FORM_LD_MY   = 7'd45;
  localparam form_t FORM_LD_MZ   = 7'd46;
  localparam form_t FORM_LD_X    = 7'd47;
  localparam form_t FORM_LD_XP   = 7'd48;
  localparam form_t FORM_LDD_Y   = 7'd49;
  localparam form_t FORM_LDD_Z   = 7'd50;
  localparam form_t FORM_LDI     = 7'd51;
  localparam form_t FORM_SER     = 7'd52;
  localparam form_t FORM_LDS     = 7'd53;
  localparam form_t FORM_LPM     = 7'd54;
  localparam form_t FORM_LPM_Z   = 7'd55;
  localparam form_t FORM_LPM_ZP  = 7'd56;
  localparam form_t FORM_LSR     = 7'd57;
  localparam form_t FORM_MOV     = 7'd58;
  localparam form_t FORM_MOVW    = 7'd59;
  localparam form_t FORM_MUL     = 7'd60;
  localparam form_t FORM_MULS    = 7'd61;
  localparam form_t FORM_MULSU   = 7'd62;
  localparam form_t FORM_NEG     = 7'd63;
  localparam form_t FORM_NOP     = 7'd64;
  localparam form_t FORM_OR      = 7'd65;
  localparam form_t FORM_ORI     = 7'd66;
  localparam form_t FORM_OUT     = 7'd67;
  localparam form_t FORM_POP     = 7'd68;
  localparam form_t FORM_PUSH    = 7'd69;
  localparam form_t FORM_RCALL   = 7'd70;
  localparam form_t FORM_RET     = 7'd71;
  localparam form_t FORM_RETI    = 7'd72;
  localparam form_t FORM_RJMP    = 7'd73;
  localparam form_t FORM_ROR     = 7'd74;
  localparam form_t FORM_SBC     = 7'd75;
  localparam form_t FORM_SBCI    = 7'd76;
  localparam form_t FORM_SBI     = 7'd77;
  localparam form_t FORM_SBIC    = 7'd78;
  localparam form_t FORM_SBIS    = 7'd79;
  localparam form_t FORM_SBIW    = 7'd80;
  localparam form_t FORM_SBRC    = 7'd81;
  localparam form_t FORM_SBRS    = 7'd82;
  localparam form_t FORM_BSET    = 7'd83;
  localparam form_t FORM_SLEEP   = 7'd84;
  localparam form_t FORM_SPM     = 7'd85;
  localparam form_t FORM_ST_X    = 7'd86;
  localparam form_t FORM_ST_XP   = 7'd87;
  localparam form_t FORM_ST_Y    = 7'd88;
  localparam form_t FORM_ST_YP   = 7'd89;
  localparam form_t FORM_ST_Z    = 7'd90;
  localparam form_t FORM_ST_ZP   = 7'd91;
  localparam form_t FORM_ST_MX   = 7'd92;
  localparam form_t FORM_ST_MY   = 7'd93;
  localparam form_t FORM_ST_MZ   = 7'd94;
  localparam form_t FORM_STD_Y   = 7'd95;
  localparam form_t FORM_STD_Z   = 7'd96;
  localparam form_t FORM_STS     = 7'd97;
  localparam form_t FORM_SUB     = 7'd98;
  localparam form_t FORM_SUBI    = 7'd99;
  localparam form_t FORM_SWAP    = 7'd100;
  localparam form_t FORM_WDR     = 7'd101;

  typedef struct packed {
    logic [15:0] mask;
    logic [15:0] match;
    form_t       code;
  } pattern_t;

  typedef struct packed {
    form_t        form_code;
    logic [4:0]   dest_reg;
    logic [4:0]   src_reg;
    logic [7:0]   immediate;
    logic [2:0]   bit_index;
    logic [11:0]  rel_offset;
    logic [21:0]  long_address;
    logic         uses_second_word;
  } result_t;

  // Entries are listed in match priority order; the first hit decides the form.
  localparam pattern_t Pats [NumPats] = '{
    '{16'hFC00, 16'h1C00, FORM_ADC},     '{16'hFC00, 16'h0C00, FORM_ADD},
    '{16'hFF00, 16'h9600, FORM_ADIW},    '{16'hFC00, 16'h2000, FORM_AND},
    '{16'hF000, 16'h7000, FORM_ANDI},    '{16'hFE0F, 16'h9405, FORM_ASR},
    '{16'hFF8F, 16'h9488, FORM_BCLR},    '{16'hFE08, 16'hF800, FORM_BLD},
    '{16'hFC00, 16'hF400, FORM_BRBC},    '{16'hFC00, 16'hF000, FORM_BRBS},
    '{16'hFFFF, 16'h9598, FORM_BREAK},   '{16'hFE08, 16'hFA00, FORM_BST},
    '{16'hFE0E, 16'h940E, FORM_CALL},    '{16'hFF00, 16'h9800, FORM_CBI},
    '{16'hFE0F, 16'h9400, FORM_COM},     '{16'hFC00, 16'h1400, FORM_CP},
    '{16'hFC00, 16'h0400, FORM_CPC},     '{16'hF000, 16'h3000, FORM_CPI},
    '{16'hFC00, 16'h1000, FORM_CPSE},    '{16'hFE0F, 16'h940A, FORM_DEC},
    '{16'hFFFF, 16'h9519, FORM_EICALL},  '{16'hFFFF, 16'h9419, FORM_EIJMP},
    '{16'hFFFF, 16'h95D8, FORM_ELPM},    '{16'hFE0F, 16'h9006, FORM_ELPM_Z},
    '{16'hFE0F, 16'h9007, FORM_ELPM_ZP}, '{16'hFC00, 16'h2400, FORM_EOR},
    '{16'hFFFF, 16'h95F8, FORM_ESPM},    '{16'hFF88, 16'h0308, FORM_FMUL},
    '{16'hFF88, 16'h0380, FORM_FMULS},   '{16'hFF88, 16'h0388, FORM_FMULSU},
    '{16'hFFFF, 16'h9509, FORM_ICALL},   '{16'hFFFF, 16'h9409, FORM_IJMP},
    '{16'hF800, 16'hB000, FORM_IN},      '{16'hFE0F, 16'h9403, FORM_INC},
    '{16'hFE0E, 16'h940C, FORM_JMP},     '{16'hFE0F, 16'h8008, FORM_LD_Y},
    '{16'hFE0F, 16'h9009, FORM_LD_YP},   '{16'hFE0F, 16'h8000, FORM_LD_Z},
    '{16'hFE0F, 16'h9001, FORM_LD_ZP},   '{16'hFE0F, 16'h900E, FORM_LD_MX},
    '{16'hFE0F, 16'h900A, FORM_LD_MY},   '{16'hFE0F, 16'h9002, FORM_LD_MZ},
    '{16'hFE0F, 16'h900C, FORM_LD_X},    '{16'hFE0F, 16'h900D, FORM_LD_XP},
    '{16'hD208, 16'h8008, FORM_LDD_Y},   '{16'hD208, 16'h8000, FORM_LDD_Z},
    '{16'hF000, 16'hE000, FORM_LDI},     '{16'hFE0F, 16'h9000, FORM_LDS},
    '{16'hFFFF, 16'h95C8, FORM_LPM},     '{16'hFE0F, 16'h9004, FORM_LPM_Z},
    '{16'hFE0F, 16'h9005, FORM_LPM_ZP},  '{16'hFE0F, 16'h9406, FORM_LSR},
    '{16'hFC00, 16'h2C00, FORM_MOV},     '{16'hFF00, 16'h0100, FORM_MOVW},
    '{16'hFC00, 16'h9C00, FORM_MUL},     '{16'hFF00, 16'h0200, FORM_MULS},
    '{16'hFF88, 16'h0300, FORM_MULSU},   '{16'hFE0F, 16'h9401, FORM_NEG},
    '{16'hFFFF, 16'h0000, FORM_NOP},     '{16'hFC00, 16'h2800, FORM_OR},
    '{16'hF000, 16'h6000, FORM_ORI},     '{16'hF800, 16'hB800, FORM_OUT},
    '{16'hFE0F, 16'h900F, FORM_POP},     '{16'hFE0F, 16'h920F, FORM_PUSH},
    '{16'hF000, 16'hD000, FORM_RCALL},   '{16'hFFFF, 16'h9508, FORM_RET},
    '{16'hFFFF, 16'h9518, FORM_RETI},    '{16'hF000, 16'hC000, FORM_RJMP},
    '{16'hFE0F, 16'h9407, FORM_ROR},     '{16'hFC00, 16'h0800, FORM_SBC},
    '{16'hF000, 16'h4000, FORM_SBCI},    '{16'hFF00, 16'h9A00, FORM_SBI},
    '{16'hFF00, 16'h9900, FORM_SBIC},    '{16'hFF00, 16'h9B00, FORM_SBIS},
    '{16'hFF00, 16'h9700, FORM_SBIW},    '{16'hFE08, 16'hFC00, FORM_SBRC},
    '{16'hFE08, 16'hFE00, FORM_SBRS},    '{16'hFF8F, 16'h9408, FORM_BSET},
    '{16'hFFFF, 16'h9588, FORM_SLEEP},   '{16'hFFFF, 16'h95E8, FORM_SPM},
    '{16'hFE0F, 16'h920C, FORM_ST_X},    '{16'hFE0F, 16'h920D, FORM_ST_XP},
    '{16'hFE0F, 16'h8208, FORM_ST_Y},    '{16'hFE0F, 16'h9209, FORM_ST_YP},
    '{16'hFE0F, 16'h8200, FORM_ST_Z},    '{16'hFE0F, 16'h9201, FORM_ST_ZP},
    '{16'hFE0F, 16'h920E, FORM_ST_MX},   '{16'hFE0F, 16'h920A, FORM_ST_MY},
    '{16'hFE0F, 16'h9202, FORM_ST_MZ},   '{16'hD208, 16'h8208, FORM_STD_Y},
    '{16'hD208, 16'h8200, FORM_STD_Z},   '{16'hFE0F, 16'h9200, FORM_STS},
    '{16'hFC00, 16'h1800, FORM_SUB},     '{16'hF000, 16'h5000, FORM_SUBI},
    '{16'hFE0F, 16'h9402, FORM_SWAP},    '{16'hFFFF, 16'h95A8, FORM_WDR}
  };

endpackage

### design/mcu_instruction_decoder_top.sv
// ----------------------------------------------------------------------------
// mcu_instruction_decoder_top
// Three-stage pipelined decoder for 8-bit MCU instruction words.
// ----------------------------------------------------------------------------
// One word can enter in every cycle while in_stall is low. An accepted word is
// registered in stage one, then in stage two, then in stage three, which drives
// the outputs. Stage one compares the word against every pattern in parallel,
// stage two picks the first hit and resolves aliases, stage three extracts the
// operand fields. A stall on the output freezes only the stages that hold words,
// and in_stall rises only when all three stages hold a word while out_stall is
// high.
module mcu_instruction_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_first_word,
  input  logic [15:0] in_second_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_form_code,
  output logic [4:0]  out_dest_reg,
  output logic [4:0]  out_src_reg,
  output logic [7:0]  out_immediate,
  output logic [2:0]  out_bit_index,
  output logic signed [11:0] out_rel_offset,
  output logic [21:0] out_long_address,
  output logic        out_uses_second_word
);

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;
  logic [15:0] w1_r, w1b_r, w2_r, w2b_r;
  logic [mcu_dec_pkg::NumPats-1:0] hit_r, hit_nxt;
  mcu_dec_pkg::form_t code_r, code_nxt;
  mcu_dec_pkg::result_t res_r, res_nxt;

  // A stage advances when it is empty or the stage after it is advancing.
  assign adv3 = !v3_r || !out_stall;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_stall = !adv1;

  always_comb begin
    for (int i = 0; i < mcu_dec_pkg::NumPats; i++) begin
      hit_nxt[i] = (in_first_word & mcu_dec_pkg::Pats[i].mask) ==
                   mcu_dec_pkg::Pats[i].match;
    end
  end

  always_comb begin
    logic [4:0] rd, rr;
    logic [7:0] k8;
    rd = w1_r[8:4];
    rr = {w1_r[9], w1_r[3:0]};
    k8 = {w1_r[11:8], w1_r[3:0]};
    code_nxt = mcu_dec_pkg::FORM_UNKNOWN;
    for (int i = mcu_dec_pkg::NumPats - 1; i >= 0; i--) begin
      if (hit_r[i]) begin
        code_nxt = mcu_dec_pkg::Pats[i].code;
      end
    end
    // Same register on both sides selects the alias form.
    if (rd == rr) begin
      unique case (code_nxt)
        mcu_dec_pkg::FORM_ADC: code_nxt = mcu_dec_pkg::FORM_ROL;
        mcu_dec_pkg::FORM_ADD: code_nxt = mcu_dec_pkg::FORM_LSL;
        mcu_dec_pkg::FORM_AND: code_nxt = mcu_dec_pkg::FORM_TST;
        mcu_dec_pkg::FORM_EOR: code_nxt = mcu_dec_pkg::FORM_CLR;
        default: ;
      endcase
    end
    if (code_nxt == mcu_dec_pkg::FORM_LDI && k8 == 8'hFF) begin
      code_nxt = mcu_dec_pkg::FORM_SER;
    end
  end

  always_comb begin
    logic [15:0] w;
    logic [4:0]  rd1, rr1;
    w   = w1b_r;
    rd1 = w[8:4];
    rr1 = {w[9], w[3:0]};
    res_nxt = '0;
    res_nxt.form_code = code_r;
    unique case (code_r)
      mcu_dec_pkg::FORM_ADC, mcu_dec_pkg::FORM_ROL, mcu_dec_pkg::FORM_ADD,
      mcu_dec_pkg::FORM_LSL, mcu_dec_pkg::FORM_AND, mcu_dec_pkg::FORM_TST,
      mcu_dec_pkg::FORM_CP, mcu_dec_pkg::FORM_CPC, mcu_dec_pkg::FORM_CPSE,
      mcu_dec_pkg::FORM_EOR, mcu_dec_pkg::FORM_CLR, mcu_dec_pkg::FORM_MOV,
      mcu_dec_pkg::FORM_MUL, mcu_dec_pkg::FORM_OR, mcu_dec_pkg::FORM_SBC,
      mcu_dec_pkg::FORM_SUB: begin
        res_nxt.dest_reg = rd1;
        res_nxt.src_reg  = rr1;
      end
      mcu_dec_pkg::FORM_ADIW, mcu_dec_pkg::FORM_SBIW: begin
        res_nxt.dest_reg  = {2'b11, w[5:4], 1'b0};
        res_nxt.immediate = {2'b00, w[7:6], w[3:0]};
      end
      mcu_dec_pkg::FORM_ANDI, mcu_dec_pkg::FORM_CPI, mcu_dec_pkg::FORM_LDI,
      mcu_dec_pkg::FORM_SER, mcu_dec_pkg::FORM_ORI, mcu_dec_pkg::FORM_SBCI,
      mcu_dec_pkg::FORM_SUBI: begin
        res_nxt.dest_reg  = {1'b1, w[7:4]};
        res_nxt.immediate = {w[11:8], w[3:0]};
      end
      mcu_dec_pkg::FORM_ASR, mcu_dec_pkg::FORM_COM, mcu_dec_pkg::FORM_DEC,
      mcu_dec_pkg::FORM_ELPM_Z, mcu_dec_pkg::FORM_ELPM_ZP, mcu_dec_pkg::FORM_INC,
      mcu_dec_pkg::FORM_LD_Y, mcu_dec_pkg::FORM_LD_YP, mcu_dec_pkg::FORM_LD_Z,
      mcu_dec_pkg::FORM_LD_ZP, mcu_dec_pkg::FORM_LD_MX, mcu_dec_pkg::FORM_LD_MY,
      mcu_dec_pkg::FORM_LD_MZ, mcu_dec_pkg::FORM_LD_X, mcu_dec_pkg::FORM_LD_XP,
      mcu_dec_pkg::FORM_LPM_Z, mcu_dec_pkg::FORM_LPM_ZP, mcu_dec_pkg::FORM_LSR,
      mcu_dec_pkg::FORM_NEG, mcu_dec_pkg::FORM_POP, mcu_dec_pkg::FORM_PUSH,
      mcu_dec_pkg::FORM_ROR, mcu_dec_pkg::FORM_ST_X, mcu_dec_pkg::FORM_ST_XP,
      mcu_dec_pkg::FORM_ST_Y, mcu_dec_pkg::FORM_ST_YP, mcu_dec_pkg::FORM_ST_Z,
      mcu_dec_pkg::FORM_ST_ZP, mcu_dec_pkg::FORM_ST_MX, mcu_dec_pkg::FORM_ST_MY,
      mcu_dec_pkg::FORM_ST_MZ, mcu_dec_pkg::FORM_SWAP: begin
        res_nxt.dest_reg = rd1;
      end
      mcu_dec_pkg::FORM_BCLR, mcu_dec_pkg::FORM_BSET: res_nxt.bit_index = w[6:4];
      mcu_dec_pkg::FORM_BLD, mcu_dec_pkg::FORM_BST, mcu_dec_pkg::FORM_SBRC,
      mcu_dec_pkg::FORM_SBRS: begin
        res_nxt.dest_reg  = rd1;
        res_nxt.bit_index = w[2:0];
      end
      mcu_dec_pkg::FORM_BRBC, mcu_dec_pkg::FORM_BRBS: begin
        res_nxt.bit_index  = w[2:0];
        res_nxt.rel_offset = {{5{w[9]}}, w[9:3]};
      end
      mcu_dec_pkg::FORM_CALL, mcu_dec_pkg::FORM_JMP: begin
        res_nxt.long_address     = {w[8:4], w[0], w2b_r};
        res_nxt.uses_second_word = 1'b1;
      end
      mcu_dec_pkg::FORM_CBI, mcu_dec_pkg::FORM_SBI, mcu_dec_pkg::FORM_SBIC,
      mcu_dec_pkg::FORM_SBIS: begin
        res_nxt.immediate = {3'b000, w[7:3]};
        res_nxt.bit_index = w[2:0];
      end
      mcu_dec_pkg::FORM_FMUL, mcu_dec_pkg::FORM_FMULS, mcu_dec_pkg::FORM_FMULSU,
      mcu_dec_pkg::FORM_MULSU: begin
        res_nxt.dest_reg = {2'b10, w[6:4]};
        res_nxt.src_reg  = {2'b10, w[2:0]};
      end
      mcu_dec_pkg::FORM_IN, mcu_dec_pkg::FORM_OUT: begin
        res_nxt.dest_reg  = rd1;
        res_nxt.immediate = {2'b00, w[10:9], w[3:0]};
      end
      mcu_dec_pkg::FORM_LDD_Y, mcu_dec_pkg::FORM_LDD_Z, mcu_dec_pkg::FORM_STD_Y,
      mcu_dec_pkg::FORM_STD_Z: begin
        res_nxt.dest_reg  = rd1;
        res_nxt.immediate = {2'b00, w[13], w[11:10], w[2:0]};
      end
      mcu_dec_pkg::FORM_LDS, mcu_dec_pkg::FORM_STS: begin
        res_nxt.dest_reg         = rd1;
        res_nxt.long_address     = {6'd0, w2b_r};
        res_nxt.uses_second_word = 1'b1;
      end
      mcu_dec_pkg::FORM_MOVW: begin
        res_nxt.dest_reg = {w[7:4], 1'b0};
        res_nxt.src_reg  = {w[3:0], 1'b0};
      end
      mcu_dec_pkg::FORM_MULS: begin
        res_nxt.dest_reg = {1'b1, w[7:4]};
        res_nxt.src_reg  = {1'b1, w[3:0]};
      end
      mcu_dec_pkg::FORM_RCALL, mcu_dec_pkg::FORM_RJMP: res_nxt.rel_offset = w[11:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      hit_r <= hit_nxt;
      w1_r  <= in_first_word;
      w2_r  <= in_second_word;
    end
    if (adv2) begin
      code_r <= code_nxt;
      w1b_r  <= w1_r;
      w2b_r  <= w2_r;
    end
    if (adv3) res_r <= res_nxt;
  end

  assign out_valid            = v3_r;
  assign out_form_code        = res_r.form_code;
  assign out_dest_reg         = res_r.dest_reg;
  assign out_src_reg          = res_r.src_reg;
  assign out_immediate        = res_r.immediate;
  assign out_bit_index        = res_r.bit_index;
  assign out_rel_offset       = res_r.rel_offset;
  assign out_long_address     = res_r.long_address;
  assign out_uses_second_word = res_r.uses_second_word;

endmodule

### design/mcu_dec_checker.sv
// ----------------------------------------------------------------------------
// mcu_dec_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module mcu_dec_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [6:0]  out_form_code,
  input logic [4:0]  out_dest_reg,
  input logic [7:0]  out_immediate,
  input logic [21:0] out_long_address,
  input logic        out_uses_second_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_form_code))
    else $error("stalled result word changed");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_form_code == mcu_dec_pkg::FORM_UNKNOWN |->
      out_dest_reg == 5'd0 && out_immediate == 8'd0 && out_long_address == 22'd0)
    else $error("unknown word has nonzero fields");

  a_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_uses_second_word |->
      out_form_code == mcu_dec_pkg::FORM_CALL || out_form_code == mcu_dec_pkg::FORM_JMP ||
      out_form_code == mcu_dec_pkg::FORM_LDS || out_form_code == mcu_dec_pkg::FORM_STS)
    else $error("second word flagged for wrong form");

endmodule

bind mcu_instruction_decoder_top mcu_dec_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_form_code(out_form_code),
  .out_dest_reg(out_dest_reg), .out_immediate(out_immediate),
  .out_long_address(out_long_address), .out_uses_second_word(out_uses_second_word)
);
